FILE: hw/rtl/id_allocator_with_translation_core_defines.svh
// Assertion macros shared by the identifier allocator RTL.
`ifndef ID_ALLOCATOR_WITH_TRANSLATION_CORE_DEFINES_SVH
`define ID_ALLOCATOR_WITH_TRANSLATION_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked on every clock edge outside reset.
`define IDAT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define IDAT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`else

`define IDAT_ASSERT(lbl, clk, rst_n, prop, msg)
`define IDAT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: hw/rtl/idat_pkg.sv
// Shared types and constants for the identifier allocator.
package idat_pkg;

  localparam int IDENT_W    = 10;
  localparam int LOC_PORT_W = 32;
  localparam int LOC_MAX_W  = 64;

  typedef enum logic [1:0] {
    CMD_ALLOC     = 2'd0,
    CMD_FREE      = 2'd1,
    CMD_RENAME    = 2'd2,
    CMD_TRANSLATE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RESERVED = 2'd1,
    ST_NOMAP    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // Update request from the controller to the free list.
  typedef struct packed {
    logic pop;
    logic push;
    logic take_fresh;
  } fl_op_t;

  // Free list condition flags seen by the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic fresh_left;
  } fl_status_t;

endpackage

FILE: hw/rtl/idat_free_list.sv
// Free identifier stack memory with its depth and fresh identifier counters.
`include "id_allocator_with_translation_core_defines.svh"

module idat_free_list #(
  parameter int ID_COUNT = 1024,
  parameter int IDX_W    = 10,
  parameter int CNT_W    = 11
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  idat_pkg::fl_op_t     op_i,
  input  logic [IDX_W-1:0]     push_id_i,
  output logic [IDX_W-1:0]     top_id_o,
  output logic [CNT_W-1:0]     next_fresh_o,
  output idat_pkg::fl_status_t stat_o
);
  import idat_pkg::*;

  logic [IDX_W-1:0] stack_mem [ID_COUNT];
  logic [IDX_W-1:0] top_q;
  logic [CNT_W-1:0] depth_q, depth_d;
  logic [CNT_W-1:0] fresh_q, fresh_d;
  logic [CNT_W-1:0] depth_m1;

  assign depth_m1 = depth_q - CNT_W'(1);

  // Stack memory: the top entry is read when a transaction is taken in,
  // and a freed identifier is written just above the top.
  always_ff @(posedge clk_i) begin
    if (op_i.push) begin
      stack_mem[depth_q[IDX_W-1:0]] <= push_id_i;
    end
    if (rd_en_i) begin
      top_q <= stack_mem[depth_m1[IDX_W-1:0]];
    end
  end

  always_comb begin
    depth_d = depth_q;
    fresh_d = fresh_q;
    if (op_i.push) begin
      depth_d = depth_q + CNT_W'(1);
    end else if (op_i.pop) begin
      depth_d = depth_m1;
    end
    if (op_i.take_fresh) begin
      fresh_d = fresh_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      fresh_q <= CNT_W'(1);
    end else begin
      depth_q <= depth_d;
      fresh_q <= fresh_d;
    end
  end

  assign top_id_o          = top_q;
  assign next_fresh_o      = fresh_q;
  assign stat_o.empty      = (depth_q == '0);
  assign stat_o.full       = (depth_q == CNT_W'(ID_COUNT));
  assign stat_o.fresh_left = (fresh_q < CNT_W'(ID_COUNT));

  `IDAT_ASSERT(a_depth_bound, clk_i, rst_ni, depth_q <= CNT_W'(ID_COUNT), "stack depth out of range")
  `IDAT_ASSERT(a_fresh_bound, clk_i, rst_ni, (fresh_q != '0) && (fresh_q <= CNT_W'(ID_COUNT)), "fresh counter out of range")
  `IDAT_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, op_i.pop && stat_o.empty, "pop from empty stack")
  `IDAT_ASSERT_NEVER(a_push_full, clk_i, rst_ni, op_i.push && stat_o.full, "push onto full stack")

endmodule

FILE: hw/rtl/id_allocator_with_translation_core.sv
// Top level of the identifier allocator with location map.
`include "id_allocator_with_translation_core_defines.svh"

// Identifier allocator with translation map. Each input transaction carries a
// command (allocate, free, rename or translate), an identifier and a location,
// and produces exactly one result transaction with an identifier, a location
// and a status. Allocate reuses the most recently freed identifier from a LIFO
// stack, or else the next never-used identifier, and records the location for
// it. Identifier 0 is reserved and is never handed out. In the cycle a
// transaction is accepted, the synchronous map and stack memories are read; in
// the S_EXEC state that follows, the result is formed and the memories and
// counters are updated. The block does not accept a new transaction until the
// current one has stored its result; it holds in S_EXEC while the result
// register is still occupied by an earlier result that has not been taken. The
// map memory is not cleared after reset, so the block is ready as soon as reset
// is released: its contents are only ever used for identifiers below the fresh
// counter, and each of those was written when it was first handed out.
module id_allocator_with_translation_core #(
  parameter int ID_COUNT       = 1024,
  parameter int LOCATION_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          command_i,
  input  logic [idat_pkg::IDENT_W-1:0]        ident_i,
  input  logic [idat_pkg::LOC_PORT_W-1:0]     location_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [idat_pkg::IDENT_W-1:0]        ident_out_o,
  output logic [idat_pkg::LOC_PORT_W-1:0]     location_out_o,
  output logic [1:0]                          status_o
);
  import idat_pkg::*;

  localparam int IDX_W = (ID_COUNT > 2) ? $clog2(ID_COUNT) : 1;
  localparam int CNT_W = $clog2(ID_COUNT + 1);
  localparam int CMP_W = (CNT_W > IDENT_W) ? CNT_W : IDENT_W;
  localparam int LOC_W = LOCATION_WIDTH;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;

  // Transaction registers captured at acceptance.
  cmd_e                  cmd_q;
  logic [IDENT_W-1:0]    ident_q;
  logic [LOC_W-1:0]      loc_q;

  // Result register.
  logic                  out_valid_q;
  logic [IDENT_W-1:0]    ident_out_q;
  logic [LOC_PORT_W-1:0] loc_out_q;
  status_e               status_q;

  logic                  accept;
  logic                  out_free;
  logic                  fire;

  logic [LOC_MAX_W-1:0]  loc_in_wide;
  logic [LOC_W-1:0]      loc_in;
  logic [CMP_W-1:0]      ident_in_cmp;
  logic [CMP_W-1:0]      ident_cmp;
  logic [IDX_W-1:0]      ident_idx;
  logic                  ident_zero;
  logic                  in_range;
  logic                  issued;

  // Map memory ports.
  logic [LOC_W-1:0]      map_mem [ID_COUNT];
  logic [LOC_W-1:0]      map_rd_q;
  logic [LOC_MAX_W-1:0]  map_rd_wide;
  logic                  map_we;
  logic [IDX_W-1:0]      map_waddr;
  logic [LOC_W-1:0]      map_wdata;

  // Free list.
  fl_op_t                fl_op, fl_op_raw;
  fl_status_t            fl_stat;
  logic [IDX_W-1:0]      top_id;
  logic [CNT_W-1:0]      next_fresh;

  // Result of the transaction in progress.
  logic [IDENT_W-1:0]    res_ident;
  logic [LOC_PORT_W-1:0] res_loc;
  status_e               res_status;
  logic                  map_we_raw;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = (state_q == S_EXEC) && out_free;

  assign loc_in_wide  = LOC_MAX_W'(location_i);
  assign loc_in       = loc_in_wide[LOC_W-1:0];
  assign ident_in_cmp = CMP_W'(ident_i);

  assign ident_cmp  = CMP_W'(ident_q);
  assign ident_idx  = ident_cmp[IDX_W-1:0];
  assign ident_zero = (ident_q == '0);
  assign in_range   = (ident_cmp < CMP_W'(ID_COUNT));
  assign issued     = (ident_cmp < CMP_W'(next_fresh));

  // The map is read at the incoming identifier when the transaction is taken
  // in; the update happens only in S_EXEC, where nothing is accepted, so a read
  // never overlaps a write to the same entry.
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (accept) begin
      map_rd_q <= map_mem[ident_in_cmp[IDX_W-1:0]];
    end
  end

  assign map_rd_wide = LOC_MAX_W'(map_rd_q);

  idat_free_list #(
    .ID_COUNT (ID_COUNT),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_free_list (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (accept),
    .op_i         (fl_op),
    .push_id_i    (ident_idx),
    .top_id_o     (top_id),
    .next_fresh_o (next_fresh),
    .stat_o       (fl_stat)
  );

  // Command decode and result formation in the S_EXEC state.
  always_comb begin
    res_ident  = '0;
    res_loc    = '0;
    res_status = ST_OK;
    map_we_raw = 1'b0;
    map_waddr  = ident_idx;
    map_wdata  = loc_q;
    fl_op_raw  = '0;
    case (cmd_q)
      CMD_ALLOC: begin
        if (!fl_stat.empty) begin
          // Reuse the most recently freed identifier.
          fl_op_raw.pop = 1'b1;
          map_we_raw    = 1'b1;
          map_waddr     = top_id;
          res_ident     = IDENT_W'(top_id);
        end else if (fl_stat.fresh_left) begin
          fl_op_raw.take_fresh = 1'b1;
          map_we_raw           = 1'b1;
          map_waddr            = next_fresh[IDX_W-1:0];
          res_ident            = IDENT_W'(next_fresh);
        end else begin
          res_status = ST_FULL;
        end
      end
      CMD_FREE: begin
        if (ident_zero) begin
          res_status = ST_RESERVED;
        end else if (!in_range) begin
          res_status = ST_NOMAP;
        end else if (fl_stat.full) begin
          res_status = ST_FULL;
        end else begin
          map_we_raw     = 1'b1;
          map_wdata      = '0;
          fl_op_raw.push = 1'b1;
        end
      end
      CMD_RENAME: begin
        if (ident_zero) begin
          res_status = ST_RESERVED;
        end else if (!in_range || !issued) begin
          res_status = ST_NOMAP;
        end else begin
          map_we_raw = 1'b1;
        end
      end
      CMD_TRANSLATE: begin
        if (ident_zero) begin
          res_status = ST_RESERVED;
        end else if (!in_range || !issued) begin
          res_status = ST_NOMAP;
        end else begin
          res_loc = map_rd_wide[LOC_PORT_W-1:0];
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // Nothing is updated until the result can be stored.
  assign map_we            = map_we_raw && fire;
  assign fl_op.pop         = fl_op_raw.pop && fire;
  assign fl_op.push        = fl_op_raw.push && fire;
  assign fl_op.take_fresh  = fl_op_raw.take_fresh && fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= CMD_ALLOC;
      ident_q     <= '0;
      loc_q       <= '0;
      out_valid_q <= 1'b0;
      ident_out_q <= '0;
      loc_out_q   <= '0;
      status_q    <= ST_OK;
    end else begin
      if (out_valid_q && out_ready_i && !fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q   <= cmd_e'(command_i);
            ident_q <= ident_i;
            loc_q   <= loc_in;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            ident_out_q <= res_ident;
            loc_out_q   <= res_loc;
            status_q    <= res_status;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ident_out_o    = ident_out_q;
  assign location_out_o = loc_out_q;
  assign status_o       = status_q;

  `IDAT_ASSERT(a_ident_ok, clk_i, rst_ni, (out_valid_q && (ident_out_q != '0)) |-> (status_q == ST_OK), "identifier handed out with error status")
  `IDAT_ASSERT(a_loc_ok, clk_i, rst_ni, (out_valid_q && (loc_out_q != '0)) |-> (status_q == ST_OK), "location returned with error status")
  `IDAT_ASSERT(a_exec_done, clk_i, rst_ni, fire |=> ((state_q == S_IDLE) && out_valid_q), "transaction did not complete")
  `IDAT_ASSERT_NEVER(a_idle_update, clk_i, rst_ni, (state_q == S_IDLE) && (map_we || fl_op.pop || fl_op.push || fl_op.take_fresh), "state update outside execution cycle")

endmodule

FILE: tb/sv/idat_tb_pkg.sv
// Result type and scoreboard with a built-in predictor for the identifier allocator testbench.
package idat_tb_pkg;

  import idat_pkg::*;

  localparam int ID_COUNT = 1024;

  typedef struct {
    logic [IDENT_W-1:0]    ident;
    logic [LOC_PORT_W-1:0] location;
    status_e               status;
  } alloc_result_t;

  class alloc_scoreboard;

    // Own copy of the block state.
    logic [LOC_PORT_W-1:0] loc_map  [ID_COUNT];
    logic [IDENT_W-1:0]    free_ids [ID_COUNT];
    logic [10:0]           free_depth;
    logic [10:0]           next_fresh;

    alloc_result_t expected_q[$];
    int unsigned   mismatches;
    int unsigned   results_seen;

    function new();
      for (int i = 0; i < ID_COUNT; i++) begin
        loc_map[i]  = '0;
        free_ids[i] = '0;
      end
      free_depth   = '0;
      next_fresh   = 11'd1;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Applies one accepted command to the predicted state and queues its result.
    function void note_command(cmd_e cmd, logic [IDENT_W-1:0] ident,
                               logic [LOC_PORT_W-1:0] location);
      alloc_result_t res;
      logic [IDENT_W-1:0] got;
      res.ident    = '0;
      res.location = '0;
      res.status   = ST_OK;
      case (cmd)
        CMD_ALLOC: begin
          if (free_depth != 0) begin
            free_depth = free_depth - 1'b1;
            got = free_ids[free_depth];
            if (got != 0) loc_map[got] = location;
            res.ident = got;
          end else if (next_fresh < ID_COUNT) begin
            res.ident = next_fresh[IDENT_W-1:0];
            loc_map[next_fresh] = location;
            next_fresh = next_fresh + 1'b1;
          end else begin
            res.status = ST_FULL;
          end
        end
        CMD_FREE: begin
          if (ident == 0) begin
            res.status = ST_RESERVED;
          end else if (free_depth >= ID_COUNT) begin
            res.status = ST_FULL;
          end else begin
            loc_map[ident] = '0;
            free_ids[free_depth] = ident;
            free_depth = free_depth + 1'b1;
          end
        end
        CMD_RENAME: begin
          if (ident == 0) res.status = ST_RESERVED;
          else if (ident >= next_fresh) res.status = ST_NOMAP;
          else loc_map[ident] = location;
        end
        default: begin
          if (ident == 0) res.status = ST_RESERVED;
          else if (ident >= next_fresh) res.status = ST_NOMAP;
          else res.location = loc_map[ident];
        end
      endcase
      expected_q.push_back(res);
    endfunction

    // Compares one accepted result with the oldest outstanding prediction.
    function void check_result(logic [IDENT_W-1:0] ident, logic [LOC_PORT_W-1:0] location,
                               logic [1:0] status);
      alloc_result_t exp_res;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with no command outstanding: ident %0d location %h status %0d",
                   ident, location, status);
        return;
      end
      exp_res = expected_q.pop_front();
      if (ident !== exp_res.ident || location !== exp_res.location ||
          status !== exp_res.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d mismatch: ident %0d/%0d location %h/%h status %0d/%0d",
                   results_seen, exp_res.ident, ident, exp_res.location, location,
                   exp_res.status, status);
      end
    endfunction

  endclass

endpackage

FILE: tb/sv/tb.sv
// Top-level testbench for the identifier allocator with translation map.
module tb;

  import idat_pkg::*;
  import idat_tb_pkg::*;

  // Generous bound on the whole run.
  localparam int unsigned LIMIT_CYCLES = 1000000;
  // Length of the one long hold-off on the result side.
  localparam int unsigned LONG_HOLD = 400;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            command_i   = CMD_ALLOC;
  logic [IDENT_W-1:0]    ident_i     = '0;
  logic [LOC_PORT_W-1:0] location_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [IDENT_W-1:0]    ident_out_o;
  logic [LOC_PORT_W-1:0] location_out_o;
  logic [1:0]            status_o;

  alloc_scoreboard sb;

  // When set, the command side offers transactions back to back.
  bit steady = 1'b0;

  id_allocator_with_translation_core #(
    .ID_COUNT      (ID_COUNT),
    .LOCATION_WIDTH(LOC_PORT_W)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .ident_i       (ident_i),
    .location_i    (location_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .ident_out_o   (ident_out_o),
    .location_out_o(location_out_o),
    .status_o      (status_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit. A run that reaches it has hung somewhere.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("tb failed");
    $finish;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Identifiers mostly come from those already issued, so that rename,
  // translate and free reach the map. The rest covers the reserved identifier,
  // the top identifier and the whole field.
  function automatic logic [IDENT_W-1:0] pick_ident();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 10) return {IDENT_W{1'b1}};
    if (r < 25 || sb.next_fresh < 2) return IDENT_W'($urandom);
    return IDENT_W'($urandom_range(1, sb.next_fresh - 1));
  endfunction

  function automatic logic [LOC_PORT_W-1:0] pick_location();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Offers one command transaction and holds it until the block takes it.
  // The scoreboard is told at the accepting edge, so the predicted state is
  // current whenever the next command is chosen. With no gap, valid simply
  // stays high and only the payload changes.
  task automatic send_command(input cmd_e cmd, input logic [IDENT_W-1:0] ident,
                              input logic [LOC_PORT_W-1:0] location);
    int unsigned gap;
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    ident_i    <= ident;
    location_i <= location;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(cmd, ident, location);
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Random mix of all four commands with the given shares of allocate and
  // free; rename and translate split the remainder.
  task automatic run_mix(input int unsigned count, input int unsigned alloc_pct,
                         input int unsigned free_pct);
    int unsigned r;
    int unsigned rename_end;
    rename_end = alloc_pct + free_pct + (100 - alloc_pct - free_pct) / 2;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct) send_command(CMD_ALLOC, IDENT_W'($urandom), pick_location());
      else if (r < alloc_pct + free_pct) send_command(CMD_FREE, pick_ident(), pick_location());
      else if (r < rename_end) send_command(CMD_RENAME, pick_ident(), pick_location());
      else send_command(CMD_TRANSLATE, pick_ident(), pick_location());
    end
  endtask

  // Every accepted result is checked against the oldest prediction. Outputs
  // are sampled at the edge, before the block updates them.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(ident_out_o, location_out_o, status_o);
  end

  // Result side: bursts of ready with random stalls between them. Once, after
  // a couple of hundred results, ready stays low for a long stretch while the
  // command side keeps offering, so that the block backs up to its input.
  initial begin : result_sink
    int unsigned stall;
    bit long_hold_done;
    long_hold_done = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!long_hold_done && sb.results_seen >= 200) begin
        long_hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
      stall = pick_gap();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The reserved identifier is ignored by every command that
    // takes one, and nothing has been issued yet.
    send_command(CMD_TRANSLATE, 10'd0, '0);
    send_command(CMD_FREE, 10'd0, '0);
    send_command(CMD_RENAME, 10'd0, 32'hFFFF_FFFF);
    send_command(CMD_TRANSLATE, 10'd1, '0);
    send_command(CMD_RENAME, 10'd1023, 32'h0000_0001);
    // Fresh identifiers 1, 2 and 3 with extreme locations.
    send_command(CMD_ALLOC, 10'd0, 32'hFFFF_FFFF);
    send_command(CMD_ALLOC, 10'd0, 32'h0000_0000);
    send_command(CMD_ALLOC, 10'd0, 32'h5A5A_A5A5);
    send_command(CMD_TRANSLATE, 10'd1, '0);
    send_command(CMD_RENAME, 10'd2, 32'hC3C3_3C3C);
    send_command(CMD_TRANSLATE, 10'd2, '0);
    // The first identifier not yet handed out has no mapping.
    send_command(CMD_TRANSLATE, 10'd4, '0);
    // A freed identifier translates to zero with an ok status.
    send_command(CMD_FREE, 10'd2, '0);
    send_command(CMD_TRANSLATE, 10'd2, '0);
    // Freeing identifiers that were never issued still pushes them.
    send_command(CMD_FREE, 10'd1000, '0);
    send_command(CMD_FREE, 10'd1023, '0);
    // The stack hands them back last in, first out.
    send_command(CMD_ALLOC, 10'd0, 32'h1234_5678);
    send_command(CMD_ALLOC, 10'd0, 32'h8000_0001);
    send_command(CMD_TRANSLATE, 10'd1000, '0);
    send_command(CMD_ALLOC, 10'd0, 32'h7FFF_FFFE);
    send_command(CMD_TRANSLATE, 10'd2, '0);
    send_command(CMD_RENAME, 10'd1, 32'h0000_0000);
    send_command(CMD_TRANSLATE, 10'd1, '0);
    // Allocate ignores its identifier field.
    send_command(CMD_ALLOC, 10'd1023, 32'hFFFF_FFFF);

    // Random traffic while fresh identifiers remain.
    run_mix(120, 45, 15);

    // Drain the stack and the fresh range back to back, with a few lookups in
    // between, then ask for more identifiers than exist.
    steady = 1'b1;
    while (!(sb.next_fresh == ID_COUNT && sb.free_depth == 0)) begin
      if ($urandom_range(0, 99) < 95) send_command(CMD_ALLOC, IDENT_W'($urandom), pick_location());
      else send_command(CMD_TRANSLATE, pick_ident(), '0);
    end
    repeat (3) send_command(CMD_ALLOC, IDENT_W'($urandom), pick_location());
    steady = 1'b0;

    // Random traffic with every identifier issued, so that identifiers go
    // onto the stack and come back off it.
    run_mix(150, 35, 25);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
